@@ hdl/vad_gap_hangover_filter_macros.svh @@
// Assertion helpers for the checker of this block.
`ifndef VAD_GAP_HANGOVER_FILTER_MACROS_SVH
`define VAD_GAP_HANGOVER_FILTER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define VGHF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define VGHF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/vghf_pkg.sv @@
`timescale 1ns / 1ps
package vghf_pkg;

	localparam int DEF_RUN_LENGTH_BITS = 20;
	localparam int DEF_MARGIN_BITS     = 10;

	localparam int THRESHOLD_W = 8;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_VOICE_THRESHOLD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_GAP         = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MARGIN_AFTER    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MARGIN_BEFORE   = 3'd3;

	localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 8'd128;

	// Slots of one burst: after-margin, non-voice middle, before-margin / whole run.
	localparam int NUM_SLOTS = 3;

	typedef struct packed {
		logic                 push;
		logic [NUM_SLOTS-1:0] keep;
		logic [NUM_SLOTS-1:0] voice;
	} vghf_push_t;

endpackage

@@ hdl/vghf_if.sv @@
`timescale 1ns / 1ps
interface vghf_chunk_if import vghf_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [THRESHOLD_W-1:0] prob_byte;
	logic                   final_chunk;
	modport source (output valid, output prob_byte, output final_chunk, input ready);
	modport sink   (input valid, input prob_byte, input final_chunk, output ready);
endinterface

interface vghf_run_if #(parameter int LEN_W = 21) ();
	logic             valid;
	logic             ready;
	logic             run_is_voice;
	logic [LEN_W-1:0] run_length;
	logic             last_of_item;
	modport source (output valid, output run_is_voice, output run_length,
		output last_of_item, input ready);
	modport sink   (input valid, input run_is_voice, input run_length,
		input last_of_item, output ready);
endinterface

interface vghf_cfg_if import vghf_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/vghf_cfg_regs.sv @@
`timescale 1ns / 1ps
module vghf_cfg_regs import vghf_pkg::*; #(
	parameter int MARGIN_BITS = DEF_MARGIN_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_valid,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	output logic [THRESHOLD_W-1:0] threshold,
	output logic [MARGIN_BITS-1:0] min_gap,
	output logic [MARGIN_BITS-1:0] after_pad,
	output logic [MARGIN_BITS-1:0] before_pad
);

	logic [THRESHOLD_W-1:0] threshold_q;
	logic [MARGIN_BITS-1:0] min_gap_q;
	logic [MARGIN_BITS-1:0] after_pad_q;
	logic [MARGIN_BITS-1:0] before_pad_q;

	// Drop upper data bits; ignore indexes past the register list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= THRESHOLD_RESET;
			min_gap_q    <= '0;
			after_pad_q  <= '0;
			before_pad_q <= '0;
		end else if (wr_valid) begin
			case (wr_index)
				REG_VOICE_THRESHOLD: threshold_q  <= wr_data[THRESHOLD_W-1:0];
				REG_MIN_GAP:         min_gap_q    <= wr_data[MARGIN_BITS-1:0];
				REG_MARGIN_AFTER:    after_pad_q  <= wr_data[MARGIN_BITS-1:0];
				REG_MARGIN_BEFORE:   before_pad_q <= wr_data[MARGIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign threshold  = threshold_q;
	assign min_gap    = min_gap_q;
	assign after_pad  = after_pad_q;
	assign before_pad = before_pad_q;

endmodule

@@ hdl/vghf_gap_core.sv @@
`timescale 1ns / 1ps
module vghf_gap_core import vghf_pkg::*; #(
	parameter int RUN_LENGTH_BITS = DEF_RUN_LENGTH_BITS,
	parameter int MARGIN_BITS     = DEF_MARGIN_BITS,
	parameter int LEN_W           = RUN_LENGTH_BITS + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [THRESHOLD_W-1:0] in_prob,
	input  logic                   in_final,
	input  logic [THRESHOLD_W-1:0] threshold,
	input  logic [MARGIN_BITS-1:0] min_gap,
	input  logic [MARGIN_BITS-1:0] after_pad,
	input  logic [MARGIN_BITS-1:0] before_pad,
	input  logic                   room,
	output vghf_push_t             push,
	output logic [LEN_W-1:0]       push_len [NUM_SLOTS]
);

	// Working width: holds the gap, the margin sum and gap + 1 without wrap.
	localparam int CW = ((RUN_LENGTH_BITS > MARGIN_BITS + 2) ?
		RUN_LENGTH_BITS : MARGIN_BITS + 2) + 1;

	logic                       valid_s1;
	logic [THRESHOLD_W-1:0]     prob_s1;
	logic                       final_s1;
	logic [RUN_LENGTH_BITS-1:0] gap_q;

	logic          closes;
	logic          advance;
	logic          long_gap;
	logic [CW-1:0] gap_w;
	logic [CW-1:0] total_w;
	logic [CW-1:0] after_w;
	logic [CW-1:0] before_w;
	logic [CW-1:0] mid_w;
	logic [CW-1:0] tail_w;

	assign closes   = final_s1 || (prob_s1 >= threshold);
	assign advance  = valid_s1 && (!closes || room);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			prob_s1  <= in_prob;
			final_s1 <= in_final;
		end
	end

	// Count open chunks, saturating; restart once the gap closes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (advance) begin
			if (closes) begin
				gap_q <= '0;
			end else if (gap_q != '1) begin
				gap_q <= gap_q + 1'b1;
			end
		end
	end

	always_comb begin
		gap_w    = CW'(gap_q);
		after_w  = CW'(after_pad);
		before_w = CW'(before_pad);
		total_w  = CW'(min_gap) + after_w + before_w;
		long_gap = gap_w > total_w;
		mid_w    = gap_w - after_w - before_w;
		tail_w   = long_gap ? (before_w + 1'b1) : (gap_w + 1'b1);
	end

	always_comb begin
		push.push   = advance && closes;
		push.keep   = {1'b1, long_gap, long_gap && (after_pad != '0)};
		push.voice  = 3'b101;
		push_len[0] = after_w[LEN_W-1:0];
		push_len[1] = mid_w[LEN_W-1:0];
		push_len[2] = tail_w[LEN_W-1:0];
	end

endmodule

@@ hdl/vghf_run_buffer.sv @@
`timescale 1ns / 1ps
module vghf_run_buffer import vghf_pkg::*; #(
	parameter int LEN_W = DEF_RUN_LENGTH_BITS + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  vghf_push_t       push,
	input  logic [LEN_W-1:0] push_len [NUM_SLOTS],
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_voice,
	output logic [LEN_W-1:0] out_len,
	output logic             out_last
);

	logic [NUM_SLOTS-1:0] keep_q;
	logic [NUM_SLOTS-1:0] voice_q;
	logic [LEN_W-1:0]     len_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] head;
	logic                 pop;

	// Head is the lowest slot still held.
	always_comb begin
		head      = keep_q & (~keep_q + 1'b1);
		out_valid = |keep_q;
		out_last  = (keep_q & ~head) == '0;
		out_voice = |(voice_q & head);
		out_len   = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (head[i]) begin
				out_len = len_q[i];
			end
		end
		pop  = out_valid && out_ready;
		room = !out_valid || (out_ready && out_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= '0;
		end else if (push.push) begin
			keep_q <= push.keep;
		end else if (pop) begin
			keep_q <= keep_q & ~head;
		end
	end

	always_ff @(posedge clk) begin
		if (push.push) begin
			voice_q <= push.voice;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				len_q[i] <= push_len[i];
			end
		end
	end

endmodule

@@ hdl/vad_gap_hangover_filter.sv @@
`timescale 1ns / 1ps
// The runs of a closing chunk pass from the input register into the run buffer,
// which shows them. Throughput: one chunk per cycle; a closing chunk waits in the input register
// until the run buffer has handed out the last word of the previous burst.
// A burst of up to three runs is handed out one run at a time, held while run.ready is low.
// Reset clears the gap count, the run buffer and the config to reset values.
module vad_gap_hangover_filter import vghf_pkg::*; #(
	parameter int RUN_LENGTH_BITS = DEF_RUN_LENGTH_BITS,
	parameter int MARGIN_BITS     = DEF_MARGIN_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	vghf_chunk_if.sink chunk,
	vghf_run_if.source run,
	vghf_cfg_if.sink   cfg
);

	localparam int LEN_W = RUN_LENGTH_BITS + 1;

	logic [THRESHOLD_W-1:0] threshold;
	logic [MARGIN_BITS-1:0] min_gap;
	logic [MARGIN_BITS-1:0] after_pad;
	logic [MARGIN_BITS-1:0] before_pad;
	logic                   room;
	vghf_push_t             push;
	logic [LEN_W-1:0]       push_len [NUM_SLOTS];

	// Config writes are taken in any cycle; the user keeps them to idle time.
	assign cfg.ready = 1'b1;

	vghf_cfg_regs #(
		.MARGIN_BITS (MARGIN_BITS)
	) u_cfg_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_valid   (cfg.valid),
		.wr_index   (cfg.index),
		.wr_data    (cfg.data),
		.threshold  (threshold),
		.min_gap    (min_gap),
		.after_pad  (after_pad),
		.before_pad (before_pad)
	);

	// Input register, gap counter and the run split of a closing chunk.
	vghf_gap_core #(
		.RUN_LENGTH_BITS (RUN_LENGTH_BITS),
		.MARGIN_BITS     (MARGIN_BITS),
		.LEN_W           (LEN_W)
	) u_gap_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (chunk.valid),
		.in_ready   (chunk.ready),
		.in_prob    (chunk.prob_byte),
		.in_final   (chunk.final_chunk),
		.threshold  (threshold),
		.min_gap    (min_gap),
		.after_pad  (after_pad),
		.before_pad (before_pad),
		.room       (room),
		.push       (push),
		.push_len   (push_len)
	);

	// Result register: holds one burst and hands it out a word at a time.
	vghf_run_buffer #(
		.LEN_W (LEN_W)
	) u_run_buffer (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_len  (push_len),
		.room      (room),
		.out_valid (run.valid),
		.out_ready (run.ready),
		.out_voice (run.run_is_voice),
		.out_len   (run.run_length),
		.out_last  (run.last_of_item)
	);

endmodule

@@ hdl/vghf_checker.sv @@
`timescale 1ns / 1ps
`include "vad_gap_hangover_filter_macros.svh"
module vghf_checker #(
	parameter int LEN_W = 21
) (
	input logic             clk,
	input logic             arst_n,
	input logic             run_valid,
	input logic             run_ready,
	input logic             run_is_voice,
	input logic [LEN_W-1:0] run_length,
	input logic             last_of_item
);

	`VGHF_ASSERT_NEXT(a_stall_hold, clk, arst_n, run_valid && !run_ready, run_valid && $stable(run_is_voice) && $stable(run_length) && $stable(last_of_item), "stalled run word changed")
	`VGHF_ASSERT_NEXT(a_burst_rest, clk, arst_n, run_valid && run_ready && !last_of_item, run_valid, "burst broken off before its last run")
	`VGHF_ASSERT_NEXT(a_gap_closed, clk, arst_n, run_valid && run_ready && !run_is_voice, run_valid && run_is_voice, "non-voice run not followed by voice run")

endmodule

bind vad_gap_hangover_filter vghf_checker #(
	.LEN_W (RUN_LENGTH_BITS + 1)
) u_vghf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.run_valid    (run.valid),
	.run_ready    (run.ready),
	.run_is_voice (run.run_is_voice),
	.run_length   (run.run_length),
	.last_of_item (run.last_of_item)
);
